FILE: sv/compensated_float_sum_8_lanes_defines.svh
// Assertion macros used by the compensated float sum RTL.
`ifndef COMPENSATED_FLOAT_SUM_8_LANES_DEFINES_SVH
`define COMPENSATED_FLOAT_SUM_8_LANES_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define CFS_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define CFS_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  `CFS_ASSERT(name, clk, rst_n, !(cond), msg)

`endif

FILE: sv/cfs_pkg.sv
// Package: constants, types and helpers of the compensated float sum.
`default_nettype none
package cfs_pkg;

  localparam int unsigned GROUP     = 8;
  localparam int unsigned LANES_DEF = 8;
  localparam int unsigned FW        = 32;
  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

  typedef enum logic {
    PAIR_ADD,
    PAIR_FOLD
  } pair_op_e;

  typedef struct packed {
    logic     start;
    pair_op_e op;
    logic     clear;
  } pair_req_t;

  typedef enum logic [2:0] {
    CTL_IDLE,
    CTL_LANES,
    CTL_TAIL,
    CTL_FOLD,
    CTL_ACC,
    CTL_FINAL,
    CTL_EMIT
  } ctl_state_e;

  function automatic logic is_nan(input logic [31:0] f);
    return (&f[30:23]) && (|f[22:0]);
  endfunction

  // |a| >= |b|, false when either is NaN
  function automatic logic mag_ge(input logic [31:0] a, input logic [31:0] b);
    return !is_nan(a) && !is_nan(b) && (a[30:0] >= b[30:0]);
  endfunction

  function automatic logic [31:0] fneg(input logic [31:0] f);
    return {~f[31], f[30:0]};
  endfunction

  function automatic logic [31:0] canon(input logic [31:0] f);
    return is_nan(f) ? CANON_NAN : f;
  endfunction

endpackage
`default_nettype wire

FILE: sv/cfs_if.sv
// Stream interfaces for input words and result words.
`default_nettype none
interface cfs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_0;
  logic [31:0] value_1;
  logic [31:0] value_2;
  logic [31:0] value_3;
  logic [31:0] value_4;
  logic [31:0] value_5;
  logic [31:0] value_6;
  logic [31:0] value_7;
  logic [3:0]  valid_count;
  logic        last_group;

  modport source (output valid, value_0, value_1, value_2, value_3, value_4, value_5,
                  value_6, value_7, valid_count, last_group, input ready);
  modport sink (input valid, value_0, value_1, value_2, value_3, value_4, value_5,
                value_6, value_7, valid_count, last_group, output ready);
endinterface

interface cfs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] total;

  modport source (output valid, total, input ready);
  modport sink (input valid, total, output ready);
endinterface
`default_nettype wire

FILE: sv/compensated_float_sum_8_lanes.sv
// Top level: compensated binary32 stream sum over parallel lanes.
`default_nettype none
// Sums a stream of IEEE single-precision words with Neumaier compensation,
// round to nearest even, subnormals kept. Each input word carries eight values,
// a count of leading valid values (9..15 act as 8) and a last flag. A full word
// sends value i to lane i mod LANES; a partial word is summed value by value
// into a tail pair. The last word folds every lane and the tail (sum plus
// compensation) and Neumaier-sums those LANES+1 values, lanes first; the result
// goes out as one word (NaN always as 0x7FC00000) and all state clears.
// Sequence: every compensated add is four dependent float adds through a pair's
// own two-stage adder. A full word is done in ceil(8/LANES) lane passes, a
// partial word takes one tail add per valid value. A last word then adds the
// fold, the merge of the LANES+1 values and the final fold before the emit.
// One word is in work at a time; a finished total waits in the output register
// and the next word is accepted meanwhile.
module compensated_float_sum_8_lanes #(
  parameter int unsigned LANES = cfs_pkg::LANES_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cfs_in_if.sink     in_i,
  cfs_out_if.source  out_o
);

  localparam int unsigned G = cfs_pkg::GROUP;

  logic [31:0]        vals [G];
  cfs_pkg::pair_req_t lane_req [LANES];
  logic [31:0]        lane_x [LANES];
  logic [31:0]        lane_res [LANES];
  logic               lane_done [LANES];
  logic               ready, accept, res_valid, emit_ok;
  logic [31:0]        res;
  logic               out_valid_q;
  logic [31:0]        total_q;

  assign vals[0] = in_i.value_0;
  assign vals[1] = in_i.value_1;
  assign vals[2] = in_i.value_2;
  assign vals[3] = in_i.value_3;
  assign vals[4] = in_i.value_4;
  assign vals[5] = in_i.value_5;
  assign vals[6] = in_i.value_6;
  assign vals[7] = in_i.value_7;

  assign in_i.ready = ready;
  assign accept     = in_i.valid && ready;

  // lanes run in lockstep; lane 0 always works, so its done stands for all
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    cfs_pair u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (lane_req[l]),
      .x_i    (lane_x[l]),
      .res_o  (lane_res[l]),
      .done_o (lane_done[l])
    );
  end

  cfs_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .value_i     (vals),
    .count_i     (in_i.valid_count),
    .last_i      (in_i.last_group),
    .ready_o     (ready),
    .lane_req_o  (lane_req),
    .lane_x_o    (lane_x),
    .lane_res_i  (lane_res),
    .lane_done_i (lane_done[0]),
    .emit_ok_i   (emit_ok),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // output register: the total waits here until taken
  assign emit_ok = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) total_q <= res;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.total = total_q;

endmodule
`default_nettype wire

FILE: sv/cfs_fadd.sv
// Two-stage binary32 adder, round to nearest even, subnormals kept.
`default_nettype none
module cfs_fadd (
  input  wire logic        clk_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [31:0] sum_o
);

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    n = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) n = 5'(26 - i);
    end
    return n;
  endfunction

  // stage 1: swap, align, add
  logic        a_nan, b_nan, a_inf, b_inf, a_big, eff_sub, sticky;
  logic [31:0] big, sml;
  logic [7:0]  eb, es, diff;
  logic [26:0] bg_ext, sm_ext, sm_sh, sm_al;
  logic [27:0] mag;

  always_comb begin
    a_nan   = cfs_pkg::is_nan(a_i);
    b_nan   = cfs_pkg::is_nan(b_i);
    a_inf   = (&a_i[30:23]) && !(|a_i[22:0]);
    b_inf   = (&b_i[30:23]) && !(|b_i[22:0]);
    a_big   = a_i[30:0] >= b_i[30:0];
    big     = a_big ? a_i : b_i;
    sml     = a_big ? b_i : a_i;
    eb      = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es      = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    diff    = eb - es;
    bg_ext  = {|big[30:23], big[22:0], 3'b000};
    sm_ext  = {|sml[30:23], sml[22:0], 3'b000};
    if (diff >= 8'd27) begin
      sm_sh  = '0;
      sticky = |sm_ext;
    end else begin
      sm_sh  = sm_ext >> diff[4:0];
      sticky = |(sm_ext & ~(27'h7FF_FFFF << diff[4:0]));
    end
    sm_al   = {sm_sh[26:1], sm_sh[0] | sticky};
    eff_sub = a_i[31] ^ b_i[31];
    mag     = eff_sub ? ({1'b0, bg_ext} - {1'b0, sm_al}) : ({1'b0, bg_ext} + {1'b0, sm_al});
  end

  logic        s1_sign_q, s1_nan_q, s1_inf_q, s1_sub_q;
  logic [7:0]  s1_exp_q;
  logic [27:0] s1_mag_q;

  always_ff @(posedge clk_i) begin
    s1_sign_q <= big[31];
    s1_nan_q  <= a_nan | b_nan | (a_inf & b_inf & eff_sub);
    s1_inf_q  <= a_inf | b_inf;
    s1_sub_q  <= eff_sub;
    s1_exp_q  <= eb;
    s1_mag_q  <= mag;
  end

  // stage 2: normalize, round, pack
  logic [4:0]  lz, sh;
  logic [7:0]  lim;
  logic [26:0] n;
  logic [9:0]  e, e2;
  logic        inc;
  logic [24:0] m25;
  logic [23:0] m;
  logic [31:0] res;

  always_comb begin
    lz  = lzc27(s1_mag_q[26:0]);
    lim = s1_exp_q - 8'd1;
    sh  = ({3'b000, lz} < lim) ? lz : lim[4:0];
    if (s1_mag_q[27]) begin
      n = {s1_mag_q[27:2], s1_mag_q[1] | s1_mag_q[0]};
      e = {2'b00, s1_exp_q} + 10'd1;
    end else begin
      n = s1_mag_q[26:0] << sh;
      e = {2'b00, s1_exp_q} - {5'd0, sh};
    end
    inc = n[2] & (n[1] | n[0] | n[3]);
    m25 = {1'b0, n[26:3]} + {24'd0, inc};
    if (m25[24]) begin
      m  = m25[24:1];
      e2 = e + 10'd1;
    end else begin
      m  = m25[23:0];
      e2 = e;
    end
    if (s1_nan_q) begin
      res = cfs_pkg::CANON_NAN;
    end else if (s1_inf_q || e2 >= 10'd255) begin
      res = {s1_sign_q, 8'hFF, 23'd0};
    end else if (s1_mag_q == 28'd0) begin
      res = {s1_sign_q & ~s1_sub_q, 31'd0};
    end else begin
      res = {s1_sign_q, m[23] ? e2[7:0] : 8'd0, m[22:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    sum_o <= res;
  end

endmodule
`default_nettype wire

FILE: sv/cfs_pair.sv
// Neumaier sum/compensation pair with its own adder: compensated add and fold.
`default_nettype none
module cfs_pair (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfs_pkg::pair_req_t req_i,
  input  wire logic [31:0]       x_i,
  output logic      [31:0]       res_o,
  output logic                   done_o
);

  // even phases issue an add, odd phases wait on the adder
  localparam logic [3:0] PH_T    = 4'd0;
  localparam logic [3:0] PH_D    = 4'd2;
  localparam logic [3:0] PH_CORR = 4'd4;
  localparam logic [3:0] PH_C    = 4'd6;
  localparam logic [3:0] PH_ADD_END  = 4'd8;
  localparam logic [3:0] PH_FOLD_END = 4'd2;

  logic [31:0] s_q, c_q, x_q, t_q;
  logic        bigs_q, busy_q;
  logic [3:0]  ph_q;
  cfs_pkg::pair_op_e op_q;
  logic [31:0] opa, opb, r;
  logic [3:0]  ph_end;

  cfs_fadd u_fadd (
    .clk_i (clk_i),
    .a_i   (opa),
    .b_i   (opb),
    .sum_o (r)
  );

  always_comb begin
    ph_end = (op_q == cfs_pkg::PAIR_ADD) ? PH_ADD_END : PH_FOLD_END;
    opa    = s_q;
    opb    = (op_q == cfs_pkg::PAIR_FOLD) ? c_q : x_q;
    if (op_q == cfs_pkg::PAIR_ADD) begin
      case (ph_q)
        PH_T: begin
          opa = s_q;
          opb = x_q;
        end
        PH_D: begin
          opa = bigs_q ? s_q : x_q;
          opb = cfs_pkg::fneg(r);
        end
        PH_CORR: begin
          opa = r;
          opb = bigs_q ? x_q : s_q;
        end
        PH_C: begin
          opa = c_q;
          opb = r;
        end
        default: begin
          opa = s_q;
          opb = x_q;
        end
      endcase
    end
  end

  assign done_o = busy_q && (ph_q == ph_end);
  assign res_o  = r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q    <= '0;
      c_q    <= '0;
      busy_q <= 1'b0;
      ph_q   <= '0;
      op_q   <= cfs_pkg::PAIR_ADD;
    end else if (req_i.clear) begin
      s_q <= '0;
      c_q <= '0;
    end else if (req_i.start && !busy_q) begin
      busy_q <= 1'b1;
      ph_q   <= '0;
      op_q   <= req_i.op;
    end else if (busy_q) begin
      if (ph_q == ph_end) begin
        busy_q <= 1'b0;
        if (op_q == cfs_pkg::PAIR_ADD) begin
          s_q <= t_q;
          c_q <= r;
        end
      end else begin
        ph_q <= ph_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      x_q    <= x_i;
      bigs_q <= cfs_pkg::mag_ge(s_q, x_i);
    end
    if (busy_q && ph_q == PH_D) t_q <= r;
  end

endmodule
`default_nettype wire

FILE: sv/cfs_merge.sv
// Sequencer: feeds the lanes, sums partial groups into the tail, merges results.
`default_nettype none
`include "compensated_float_sum_8_lanes_defines.svh"
module cfs_merge #(
  parameter int unsigned LANES = cfs_pkg::LANES_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [31:0]        value_i [cfs_pkg::GROUP],
  input  wire logic [3:0]         count_i,
  input  wire logic               last_i,
  output logic                    ready_o,
  output cfs_pkg::pair_req_t      lane_req_o [LANES],
  output logic      [31:0]        lane_x_o [LANES],
  input  wire logic [31:0]        lane_res_i [LANES],
  input  wire logic               lane_done_i,
  input  wire logic               emit_ok_i,
  output logic                    res_valid_o,
  output logic      [31:0]        res_o
);

  localparam int unsigned G    = cfs_pkg::GROUP;
  localparam int unsigned NFLD = LANES + 1;

  cfs_pkg::ctl_state_e state_q, state_d;
  logic        go_q, go_d, last_q;
  logic [3:0]  rem_q, rem_d, cnt_c, rem_lane, rem_one;
  logic [31:0] vals_q [G];
  logic [31:0] fold_q [NFLD];
  logic [31:0] res_q;

  cfs_pkg::pair_req_t tail_req, acc_req;
  logic [31:0] tail_res, acc_res;
  logic        tail_done, acc_done;

  cfs_pair u_tail (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tail_req),
    .x_i    (vals_q[0]),
    .res_o  (tail_res),
    .done_o (tail_done)
  );

  cfs_pair u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (acc_req),
    .x_i    (fold_q[0]),
    .res_o  (acc_res),
    .done_o (acc_done)
  );

  assign cnt_c    = (count_i > 4'(G)) ? 4'(G) : count_i;
  assign rem_lane = (rem_q > 4'(LANES)) ? (rem_q - 4'(LANES)) : 4'd0;
  assign rem_one  = (rem_q != 4'd0) ? (rem_q - 4'd1) : 4'd0;

  // next state
  always_comb begin
    state_d = state_q;
    go_d    = go_q;
    rem_d   = rem_q;
    case (state_q)
      cfs_pkg::CTL_IDLE: begin
        go_d = 1'b0;
        if (start_i) begin
          if (cnt_c == 4'(G)) begin
            state_d = cfs_pkg::CTL_LANES;
            rem_d   = 4'(G);
          end else if (cnt_c != 4'd0) begin
            state_d = cfs_pkg::CTL_TAIL;
            rem_d   = cnt_c;
          end else if (last_i) begin
            state_d = cfs_pkg::CTL_FOLD;
          end
        end
      end
      cfs_pkg::CTL_LANES: begin
        if (!go_q) go_d = 1'b1;
        else if (lane_done_i) begin
          go_d  = 1'b0;
          rem_d = rem_lane;
          if (rem_lane == 4'd0) state_d = last_q ? cfs_pkg::CTL_FOLD : cfs_pkg::CTL_IDLE;
        end
      end
      cfs_pkg::CTL_TAIL: begin
        if (!go_q) go_d = 1'b1;
        else if (tail_done) begin
          go_d  = 1'b0;
          rem_d = rem_one;
          if (rem_one == 4'd0) state_d = last_q ? cfs_pkg::CTL_FOLD : cfs_pkg::CTL_IDLE;
        end
      end
      cfs_pkg::CTL_FOLD: begin
        if (!go_q) go_d = 1'b1;
        else if (tail_done) begin
          go_d    = 1'b0;
          rem_d   = 4'(NFLD);
          state_d = cfs_pkg::CTL_ACC;
        end
      end
      cfs_pkg::CTL_ACC: begin
        if (!go_q) go_d = 1'b1;
        else if (acc_done) begin
          go_d  = 1'b0;
          rem_d = rem_one;
          if (rem_one == 4'd0) state_d = cfs_pkg::CTL_FINAL;
        end
      end
      cfs_pkg::CTL_FINAL: begin
        if (!go_q) go_d = 1'b1;
        else if (acc_done) begin
          go_d    = 1'b0;
          state_d = cfs_pkg::CTL_EMIT;
        end
      end
      cfs_pkg::CTL_EMIT: begin
        if (emit_ok_i) state_d = cfs_pkg::CTL_IDLE;
      end
      default: state_d = cfs_pkg::CTL_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    logic clr;
    clr         = (state_q == cfs_pkg::CTL_EMIT) && emit_ok_i;
    ready_o     = (state_q == cfs_pkg::CTL_IDLE);
    res_valid_o = clr;
    res_o       = res_q;
    tail_req    = '{start: 1'b0, op: cfs_pkg::PAIR_ADD, clear: clr};
    acc_req     = '{start: 1'b0, op: cfs_pkg::PAIR_ADD, clear: clr};
    for (int l = 0; l < LANES; l++) begin
      lane_req_o[l] = '{start: 1'b0, op: cfs_pkg::PAIR_ADD, clear: clr};
      lane_x_o[l]   = vals_q[l];
    end
    if (!go_q) begin
      case (state_q)
        cfs_pkg::CTL_LANES: begin
          for (int l = 0; l < LANES; l++) lane_req_o[l].start = rem_q > 4'(l);
        end
        cfs_pkg::CTL_TAIL: tail_req.start = 1'b1;
        cfs_pkg::CTL_FOLD: begin
          tail_req = '{start: 1'b1, op: cfs_pkg::PAIR_FOLD, clear: 1'b0};
          for (int l = 0; l < LANES; l++) begin
            lane_req_o[l] = '{start: 1'b1, op: cfs_pkg::PAIR_FOLD, clear: 1'b0};
          end
        end
        cfs_pkg::CTL_ACC:   acc_req.start = 1'b1;
        cfs_pkg::CTL_FINAL: acc_req = '{start: 1'b1, op: cfs_pkg::PAIR_FOLD, clear: 1'b0};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfs_pkg::CTL_IDLE;
      go_q    <= 1'b0;
      rem_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= go_d;
      rem_q   <= rem_d;
      if (start_i && state_q == cfs_pkg::CTL_IDLE) last_q <= last_i;
    end
  end

  // item shift line, fold values, result
  always_ff @(posedge clk_i) begin
    if (start_i && state_q == cfs_pkg::CTL_IDLE) begin
      for (int i = 0; i < G; i++) vals_q[i] <= value_i[i];
    end else if (state_q == cfs_pkg::CTL_LANES && go_q && lane_done_i) begin
      for (int i = 0; i < G; i++) vals_q[i] <= (i + LANES < G) ? vals_q[i + LANES] : '0;
    end else if (state_q == cfs_pkg::CTL_TAIL && go_q && tail_done) begin
      for (int i = 0; i < G; i++) vals_q[i] <= (i + 1 < G) ? vals_q[i + 1] : '0;
    end
    if (state_q == cfs_pkg::CTL_FOLD && go_q && tail_done) begin
      for (int l = 0; l < LANES; l++) fold_q[l] <= lane_res_i[l];
      fold_q[LANES] <= tail_res;
    end else if (state_q == cfs_pkg::CTL_ACC && go_q && acc_done) begin
      for (int i = 0; i < NFLD; i++) fold_q[i] <= (i + 1 < NFLD) ? fold_q[i + 1] : '0;
    end
    if (state_q == cfs_pkg::CTL_FINAL && go_q && acc_done) res_q <= cfs_pkg::canon(acc_res);
  end

  `CFS_ASSERT(a_lane_done_state, clk_i, rst_ni, lane_done_i |-> (state_q == cfs_pkg::CTL_LANES || state_q == cfs_pkg::CTL_FOLD), "lane finished outside lane or fold phase")
  `CFS_ASSERT(a_acc_done_state, clk_i, rst_ni, acc_done |-> (state_q == cfs_pkg::CTL_ACC || state_q == cfs_pkg::CTL_FINAL), "merge pair finished outside merge phase")
  `CFS_ASSERT(a_emit_to_idle, clk_i, rst_ni, res_valid_o |=> (state_q == cfs_pkg::CTL_IDLE), "no return to idle after result")
  `CFS_ASSERT_NEVER(a_rem_range, clk_i, rst_ni, rem_q > 4'(G + 1), "remaining count out of range")

endmodule
`default_nettype wire
